// ----- design/drpi_pkg.sv -----
// ----------------------------------------------------------------------------
// drpi_pkg
// Types, widths, constants and helper functions of the dead-reckoning pose
// integrator.
// ----------------------------------------------------------------------------
package drpi_pkg;

  localparam int SPEED_W = 24;
  localparam int DT_W    = 24;
  localparam int POS_W   = 32;
  localparam int ANG_W   = 32;

  localparam int CORDIC_ITERATIONS = 24;
  localparam int CORDIC_CNT_W      = $clog2(CORDIC_ITERATIONS + 1);
  localparam int CORDIC_W          = 34;
  localparam int ATAN_IDX_W        = 5;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // Distance and turn are the 48-bit speed * time_step products shifted by 16.
  localparam int DIST_LSB = 16;
  localparam int DIST_W   = 32;

  // The turn times 1/(2*pi) in Q32 is rounded and shifted by 24.
  localparam int DTH_LSB = 24;
  localparam logic signed [PROD_W-1:0] DTH_RND = PROD_W'(64'd1 << 23);

  // The distance times sine or cosine is rounded and shifted by 38.
  localparam int DELTA_LSB = 38;
  localparam int DELTA_W   = PROD_W - DELTA_LSB;
  localparam logic signed [PROD_W-1:0] DELTA_RND = PROD_W'(64'd1 << 37);

  localparam logic signed [MUL_W-1:0]    INV_TWO_PI_Q32 = MUL_W'(64'd683565276);
  localparam logic signed [CORDIC_W-1:0] CORDIC_SEED    = CORDIC_W'(64'd652032874);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [DT_W-1:0] TIME_STEP_RST = DT_W'(167772);

  typedef enum logic [1:0] {
    REG_TIME_STEP     = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2,
    REG_START_HEADING = 2'd3
  } cfg_reg_e;

  localparam logic REQ_STEP    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic             start;
    logic [ANG_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [CORDIC_W-1:0] sin_val;
    logic signed [CORDIC_W-1:0] cos_val;
  } cordic_rsp_t;

  // Arctangent of 2^-k as a binary angle with 2^31 equal to pi.
  function automatic logic signed [CORDIC_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] k);
    logic signed [CORDIC_W-1:0] r;
    unique case (k)
      5'd0:  r = CORDIC_W'(64'd536870912);
      5'd1:  r = CORDIC_W'(64'd316933406);
      5'd2:  r = CORDIC_W'(64'd167458907);
      5'd3:  r = CORDIC_W'(64'd85004756);
      5'd4:  r = CORDIC_W'(64'd42667331);
      5'd5:  r = CORDIC_W'(64'd21354465);
      5'd6:  r = CORDIC_W'(64'd10679838);
      5'd7:  r = CORDIC_W'(64'd5340245);
      5'd8:  r = CORDIC_W'(64'd2670163);
      5'd9:  r = CORDIC_W'(64'd1335087);
      5'd10: r = CORDIC_W'(64'd667544);
      5'd11: r = CORDIC_W'(64'd333772);
      5'd12: r = CORDIC_W'(64'd166886);
      5'd13: r = CORDIC_W'(64'd83443);
      5'd14: r = CORDIC_W'(64'd41722);
      5'd15: r = CORDIC_W'(64'd20861);
      5'd16: r = CORDIC_W'(64'd10430);
      5'd17: r = CORDIC_W'(64'd5215);
      5'd18: r = CORDIC_W'(64'd2608);
      5'd19: r = CORDIC_W'(64'd1304);
      5'd20: r = CORDIC_W'(64'd652);
      5'd21: r = CORDIC_W'(64'd326);
      5'd22: r = CORDIC_W'(64'd163);
      5'd23: r = CORDIC_W'(64'd81);
      5'd24: r = CORDIC_W'(64'd41);
      5'd25: r = CORDIC_W'(64'd20);
      5'd26: r = CORDIC_W'(64'd10);
      5'd27: r = CORDIC_W'(64'd5);
      5'd28: r = CORDIC_W'(64'd3);
      5'd29: r = CORDIC_W'(64'd1);
      5'd30: r = CORDIC_W'(64'd1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Adds a position delta and clamps to the Q16.16 range.
  function automatic logic signed [POS_W-1:0] sat_add(input logic signed [POS_W-1:0]   a,
                                                      input logic signed [DELTA_W-1:0] d);
    logic signed [POS_W:0] s;
    logic signed [POS_W-1:0] r;
    s = (POS_W+1)'(a) + (POS_W+1)'(d);
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/drpi_in_if.sv -----
// ----------------------------------------------------------------------------
// drpi_in_if
// Request channel of the pose integrator: step or restart requests.
// ----------------------------------------------------------------------------
interface drpi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [drpi_pkg::SPEED_W-1:0] forward_speed;
  logic signed [drpi_pkg::SPEED_W-1:0] rotation_speed;

  modport source (
    output valid, req_type, forward_speed, rotation_speed,
    input  ready
  );

  modport sink (
    input  valid, req_type, forward_speed, rotation_speed,
    output ready
  );
endinterface

// ----- design/drpi_out_if.sv -----
// ----------------------------------------------------------------------------
// drpi_out_if
// Result channel of the pose integrator: the pose after each request.
// ----------------------------------------------------------------------------
interface drpi_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [drpi_pkg::POS_W-1:0] pos_x;
  logic signed [drpi_pkg::POS_W-1:0] pos_y;
  logic signed [drpi_pkg::ANG_W-1:0] heading;

  modport source (
    output valid, pos_x, pos_y, heading,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, heading,
    output ready
  );
endinterface

// ----- design/drpi_mult.sv -----
// ----------------------------------------------------------------------------
// drpi_mult
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module drpi_mult (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [drpi_pkg::MUL_W-1:0]    a_i,
  input  logic signed [drpi_pkg::MUL_W-1:0]    b_i,
  output logic signed [drpi_pkg::PROD_W-1:0]   prod_o
);
  import drpi_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

// ----- design/drpi_cordic.sv -----
// ----------------------------------------------------------------------------
// drpi_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, giving sine
// and cosine of a binary angle in Q1.30.
// ----------------------------------------------------------------------------
module drpi_cordic (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drpi_pkg::cordic_req_t req_i,
  output drpi_pkg::cordic_rsp_t rsp_o
);
  import drpi_pkg::*;

  logic                       busy_q;
  logic                       done_q;
  logic [CORDIC_CNT_W-1:0]    cnt_q;
  logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
  logic                       flip_q;

  logic                       flip;
  logic [ANG_W-1:0]           folded;
  logic [ATAN_IDX_W-1:0]      k;
  logic signed [CORDIC_W-1:0] xs, ys, atan_k;
  logic                       last;

  // Angles in the second and third quadrant are turned by pi; both results
  // are negated at the end to undo it.
  assign flip   = req_i.angle[ANG_W-1] ^ req_i.angle[ANG_W-2];
  assign folded = req_i.angle ^ {flip, {(ANG_W-1){1'b0}}};

  assign k      = ATAN_IDX_W'(cnt_q);
  assign xs     = x_q >>> k;
  assign ys     = y_q >>> k;
  assign atan_k = atan_lut(k);
  assign last   = (cnt_q == CORDIC_CNT_W'(CORDIC_ITERATIONS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q    <= CORDIC_SEED;
      y_q    <= '0;
      z_q    <= CORDIC_W'($signed(folded));
      flip_q <= flip;
    end else if (busy_q) begin
      if (!z_q[CORDIC_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_k;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_k;
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.sin_val = flip_q ? -y_q : y_q;
  assign rsp_o.cos_val = flip_q ? -x_q : x_q;

endmodule

// ----- design/dead_reckoning_pose_integrator.sv -----
// ----------------------------------------------------------------------------
// dead_reckoning_pose_integrator
// Unicycle odometry: keeps east, north and heading and advances them by one
// integration step per request, or loads the configured start pose.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | contents
//  in_ch    | in  | valid / ready    | req_type, forward_speed, rotation_speed
//  out_ch   | out | valid / ready    | pos_x, pos_y, heading
//  APB      | in  | psel / penable   | time_step, start_x, start_y, start_heading
//
// A step request runs the 24 CORDIC iterations and then the two sine and
// cosine multiplies on the shared multiplier. A restart request loads the
// start pose and goes to the hold state. One request is worked on at a time;
// a new one is taken while the previous result waits in the output register.
// Reset is asynchronous and active low and clears the pose to the origin.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_integrator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  drpi_in_if.sink                             in_ch,
  drpi_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [drpi_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [drpi_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [drpi_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import drpi_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE        = 9'b000000001,
    ST_MUL_DIST    = 9'b000000010,
    ST_MUL_TURN    = 9'b000000100,
    ST_MUL_DTH     = 9'b000001000,
    ST_WAIT_CORDIC = 9'b000010000,
    ST_MUL_DX      = 9'b000100000,
    ST_MUL_DY      = 9'b001000000,
    ST_FINISH      = 9'b010000000,
    ST_HOLD        = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [DT_W-1:0]         time_step_q;
  logic signed [POS_W-1:0] start_x_q, start_y_q;
  logic [ANG_W-1:0]        start_hdg_q;

  // Pose.
  logic signed [POS_W-1:0] east_q, north_q;
  logic [ANG_W-1:0]        hdg_q;

  // Working registers.
  logic signed [SPEED_W-1:0] v_q, w_q;
  logic signed [DIST_W-1:0]  dist_q;
  logic [ANG_W-1:0]          dth_q;

  // Output register.
  logic                    out_vld_q;
  logic signed [POS_W-1:0] out_x_q, out_y_q;
  logic [ANG_W-1:0]        out_hdg_q;

  logic in_acc, out_free, cfg_wr;

  logic                     mul_en;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] dth_sum, delta_sum;
  logic signed [DELTA_W-1:0] delta;

  cordic_req_t creq;
  cordic_rsp_t crsp;

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign out_free = ~out_vld_q | out_ch.ready;
  assign in_ch.ready = (state_q == ST_IDLE);

  // ---------------------------------------------------------------- APB port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TIME_STEP_RST;
      start_x_q   <= '0;
      start_y_q   <= '0;
      start_hdg_q <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(paddr[APB_ADDR_W-1:2]))
        REG_TIME_STEP:     time_step_q <= pwdata[DT_W-1:0];
        REG_START_X:       start_x_q   <= $signed(pwdata);
        REG_START_Y:       start_y_q   <= $signed(pwdata);
        REG_START_HEADING: start_hdg_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[APB_ADDR_W-1:2]))
      REG_TIME_STEP:     prdata = APB_DATA_W'(time_step_q);
      REG_START_X:       prdata = start_x_q;
      REG_START_Y:       prdata = start_y_q;
      REG_START_HEADING: prdata = start_hdg_q;
      default:           prdata = '0;
    endcase
  end

  // ----------------------------------------------------------- shared units
  assign creq.start = in_acc & (in_ch.req_type == REQ_STEP);
  assign creq.angle = hdg_q;

  drpi_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (creq),
    .rsp_o  (crsp)
  );

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MUL_DIST: begin
        mul_a = MUL_W'(v_q);
        mul_b = $signed({{(MUL_W-DT_W){1'b0}}, time_step_q});
      end
      ST_MUL_TURN: begin
        mul_a = MUL_W'(w_q);
        mul_b = $signed({{(MUL_W-DT_W){1'b0}}, time_step_q});
      end
      ST_MUL_DTH: begin
        // The product register holds rotation_speed * time_step here.
        mul_a = MUL_W'($signed(prod[DIST_LSB+DIST_W-1:DIST_LSB]));
        mul_b = INV_TWO_PI_Q32;
      end
      ST_MUL_DX: begin
        mul_a = MUL_W'(dist_q);
        mul_b = crsp.sin_val;
      end
      ST_MUL_DY: begin
        mul_a = MUL_W'(dist_q);
        mul_b = crsp.cos_val;
      end
      default: mul_en = 1'b0;
    endcase
  end

  drpi_mult u_mult (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign dth_sum   = prod + DTH_RND;
  assign delta_sum = prod + DELTA_RND;
  assign delta     = delta_sum[PROD_W-1:DELTA_LSB];

  // -------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_ch.req_type == REQ_RESTART) ? ST_HOLD : ST_MUL_DIST;
        end
      end
      ST_MUL_DIST:    state_d = ST_MUL_TURN;
      ST_MUL_TURN:    state_d = ST_MUL_DTH;
      ST_MUL_DTH:     state_d = ST_WAIT_CORDIC;
      ST_WAIT_CORDIC: if (crsp.done) state_d = ST_MUL_DX;
      ST_MUL_DX:      state_d = ST_MUL_DY;
      ST_MUL_DY:      state_d = ST_FINISH;
      ST_FINISH:      state_d = ST_HOLD;
      ST_HOLD:        if (out_free) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      east_q    <= '0;
      north_q   <= '0;
      hdg_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_ch.req_type == REQ_RESTART) begin
        east_q  <= start_x_q;
        north_q <= start_y_q;
        hdg_q   <= start_hdg_q;
      end
      if (state_q == ST_MUL_DY) begin
        east_q <= sat_add(east_q, delta);
      end
      if (state_q == ST_FINISH) begin
        north_q <= sat_add(north_q, delta);
        hdg_q   <= hdg_q + dth_q;
      end
      if (state_q == ST_HOLD && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q <= in_ch.forward_speed;
      w_q <= in_ch.rotation_speed;
    end
    if (state_q == ST_MUL_TURN) begin
      dist_q <= prod[DIST_LSB+DIST_W-1:DIST_LSB];
    end
    // The product stays put while the CORDIC finishes, so repeated loads agree.
    if (state_q == ST_WAIT_CORDIC) begin
      dth_q <= dth_sum[DTH_LSB+ANG_W-1:DTH_LSB];
    end
    if (state_q == ST_HOLD && out_free) begin
      out_x_q   <= east_q;
      out_y_q   <= north_q;
      out_hdg_q <= hdg_q;
    end
  end

  assign out_ch.valid   = out_vld_q;
  assign out_ch.pos_x   = out_x_q;
  assign out_ch.pos_y   = out_y_q;
  assign out_ch.heading = $signed(out_hdg_q);

  // ------------------------------------------------------------- assertions
  a_cordic_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL_DX |-> crsp.done)
    else $error("sine and cosine used before the CORDIC finished");

  a_restart_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_ch.req_type == REQ_RESTART |=>
      east_q == $past(start_x_q) && north_q == $past(start_y_q) &&
      hdg_q == $past(start_hdg_q))
    else $error("restart did not load the start pose");

  a_heading_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> hdg_q == $past(hdg_q + dth_q))
    else $error("heading not advanced by the turn increment");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD && out_free |=>
      out_vld_q && out_x_q == $past(east_q) && out_hdg_q == $past(hdg_q))
    else $error("result register not loaded from the pose");

endmodule
